// ----- sv/lrs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared constants, the stored element format and the divide-by-ten helper
// for the base-10 radix sorter.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 31;
  localparam int RADIX     = 10;
  localparam int DIG_W     = $clog2(RADIX);

  // ceil(2^35 / 10), exact quotient for any 32-bit dividend
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  // a stored element carries its value and the value scaled down to the
  // current decimal place
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] quot;
  } elem_t;

  function automatic logic [VAL_W-1:0] div10(input logic [VAL_W-1:0] q);
    logic [63:0] prod;
    prod = {33'd0, q} * {32'd0, RECIP10};
    return VAL_W'(prod[63:35]);
  endfunction

endpackage
`default_nettype wire

// ----- sv/lrs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module lrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/lrs_digit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_digit
// Digit extraction stage: divides the element's scaled quotient by ten
// (reciprocal multiply, registered) and yields the decimal digit at the
// current place together with the quotient for the next place.
// ----------------------------------------------------------------------------
module lrs_digit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire lrs_pkg::elem_t             in_elem,
  output logic                            out_valid,
  output logic [lrs_pkg::VAL_W-1:0]       value,
  output logic [lrs_pkg::VAL_W-1:0]       quot,
  output logic [lrs_pkg::DIG_W-1:0]       digit
);
  import lrs_pkg::*;

  logic [DIG_W-1:0] q_low;
  logic [DIG_W-1:0] qd10_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    value <= in_elem.value;
    q_low <= in_elem.quot[DIG_W-1:0];
    quot  <= div10(in_elem.quot);
  end

  // digit = q - 10*(q/10); only the low four bits matter since digit < 10
  assign qd10_low = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign digit    = q_low - qd10_low;

endmodule
`default_nettype wire

// ----- sv/lsd_radix_sort_base10.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsd_radix_sort_base10
// Streaming LSD radix sorter, base 10, for runs of up to 64 non-negative
// 31-bit values.
// ----------------------------------------------------------------------------
// Values are loaded at one per cycle into a 64-entry RAM; a value that arrives
// while 64 are already stored is dropped. The item marked last starts the sort
// and in_ready stays low until the final sorted value has been taken. Each
// decimal place of the run maximum costs one pass over the n stored values:
// it builds the digit histogram, forms the prefix sums, places the elements
// from the back into the other RAM, and swaps the two RAMs. The passes are
// paced by the single read port of each RAM and the registered divide-by-ten
// stage behind it. A maximum of zero runs no pass. The sorted values then leave
// in ascending order while out_ready is high, each only after the one before it
// has been taken, the final one with last_out set. Reads and writes of a pass
// always go to different RAMs, so no forwarding is needed.
// ----------------------------------------------------------------------------
module lsd_radix_sort_base10 (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [lrs_pkg::VAL_W-1:0]  value,
  input  wire logic                       last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [lrs_pkg::VAL_W-1:0]       sorted_value,
  output logic                            last_out
);
  import lrs_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_COUNT,
    S_PREFIX,
    S_PLACE,
    S_PASS_END,
    S_EMIT_RD,
    S_EMIT_WAIT,
    S_EMIT_HOLD
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] max_val;
  logic [VAL_W-1:0] max_q;
  logic             sel;
  logic [CNT_W-1:0] issued;
  logic             rd_v1;
  logic [DIG_W-1:0] pidx;
  logic [ADDR_W-1:0] eidx;
  logic [CNT_W-1:0] hist [RADIX];

  logic             full;
  logic [VAL_W-1:0] max_in;
  logic             issuing;
  logic             drained;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] last_idx;
  logic [ADDR_W-1:0] pos;
  logic [VAL_W-1:0] max_q_next;

  logic             load_we;
  logic             place_we;
  elem_t            load_elem;
  elem_t            place_elem;
  elem_t            rdata_a;
  elem_t            rdata_b;
  elem_t            src_data;
  logic             we_a;
  logic             we_b;
  logic [ADDR_W-1:0] waddr_a;
  logic [ADDR_W-1:0] waddr_b;
  elem_t            wdata_a;
  elem_t            wdata_b;

  logic             du_valid;
  logic [VAL_W-1:0] du_value;
  logic [VAL_W-1:0] du_quot;
  logic [DIG_W-1:0] du_digit;

  assign in_ready   = (state == S_LOAD);
  assign full       = (cnt == CNT_W'(MAX_ITEMS));
  assign max_in     = (!full && (value > max_val)) ? value : max_val;
  assign issuing    = ((state == S_COUNT) || (state == S_PLACE)) && (issued != cnt);
  assign drained    = !issuing && !rd_v1 && !du_valid;
  assign last_idx   = ADDR_W'(cnt - CNT_W'(1));
  assign pos        = ADDR_W'(hist[du_digit] - CNT_W'(1));
  assign max_q_next = div10(max_q);

  always_comb begin
    case (state)
      S_COUNT:     rd_addr = issued[ADDR_W-1:0];
      S_PLACE:     rd_addr = ADDR_W'(cnt - CNT_W'(1) - issued);
      S_EMIT_HOLD: rd_addr = eidx + ADDR_W'(1);
      default:     rd_addr = eidx;
    endcase
  end

  // sel names the RAM that holds the current run; placement writes the other
  assign load_we    = (state == S_LOAD) && in_valid && !full;
  assign place_we   = (state == S_PLACE) && du_valid;
  assign load_elem  = '{value: value, quot: value};
  assign place_elem = '{value: du_value, quot: du_quot};
  assign src_data   = sel ? rdata_b : rdata_a;

  assign we_a    = sel ? place_we : load_we;
  assign waddr_a = sel ? pos : cnt[ADDR_W-1:0];
  assign wdata_a = sel ? place_elem : load_elem;
  assign we_b    = sel ? load_we : place_we;
  assign waddr_b = sel ? cnt[ADDR_W-1:0] : pos;
  assign wdata_b = sel ? load_elem : place_elem;

  lrs_ram #(.WIDTH($bits(elem_t)), .DEPTH(MAX_ITEMS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .raddr (rd_addr),
    .rdata (rdata_a)
  );

  lrs_ram #(.WIDTH($bits(elem_t)), .DEPTH(MAX_ITEMS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (wdata_b),
    .raddr (rd_addr),
    .rdata (rdata_b)
  );

  lrs_digit u_digit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_v1),
    .in_elem   (src_data),
    .out_valid (du_valid),
    .value     (du_value),
    .quot      (du_quot),
    .digit     (du_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      max_val   <= '0;
      max_q     <= '0;
      sel       <= 1'b0;
      issued    <= '0;
      rd_v1     <= 1'b0;
      pidx      <= '0;
      eidx      <= '0;
      out_valid <= 1'b0;
      last_out  <= 1'b0;
      for (int i = 0; i < RADIX; i++) begin
        hist[i] <= '0;
      end
    end else begin
      rd_v1 <= issuing;
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (!full) begin
              cnt     <= cnt + CNT_W'(1);
              max_val <= max_in;
            end
            if (last) begin
              max_q  <= max_in;
              issued <= '0;
              eidx   <= '0;
              for (int i = 0; i < RADIX; i++) begin
                hist[i] <= '0;
              end
              state <= (max_in != '0) ? S_COUNT : S_EMIT_RD;
            end
          end
        end
        S_COUNT: begin
          if (issuing) begin
            issued <= issued + CNT_W'(1);
          end
          if (du_valid) begin
            hist[du_digit] <= hist[du_digit] + CNT_W'(1);
          end
          if (drained) begin
            pidx  <= DIG_W'(1);
            state <= S_PREFIX;
          end
        end
        S_PREFIX: begin
          hist[pidx] <= hist[pidx] + hist[pidx - DIG_W'(1)];
          if (pidx == DIG_W'(RADIX - 1)) begin
            issued <= '0;
            state  <= S_PLACE;
          end else begin
            pidx <= pidx + DIG_W'(1);
          end
        end
        S_PLACE: begin
          if (issuing) begin
            issued <= issued + CNT_W'(1);
          end
          // scanning from the back keeps the placement stable
          if (du_valid) begin
            hist[du_digit] <= hist[du_digit] - CNT_W'(1);
          end
          if (drained) begin
            state <= S_PASS_END;
          end
        end
        S_PASS_END: begin
          sel    <= ~sel;
          max_q  <= max_q_next;
          issued <= '0;
          eidx   <= '0;
          for (int i = 0; i < RADIX; i++) begin
            hist[i] <= '0;
          end
          state <= (max_q_next != '0) ? S_COUNT : S_EMIT_RD;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          sorted_value <= src_data.value;
          last_out     <= (eidx == last_idx);
          out_valid    <= 1'b1;
          state        <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_out) begin
              cnt     <= '0;
              max_val <= '0;
              state   <= S_LOAD;
            end else begin
              eidx  <= eidx + ADDR_W'(1);
              state <= S_EMIT_WAIT;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // no request is taken while a sorted value waits
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input accepted while output pending");

  // fill count never passes the store depth
  assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(MAX_ITEMS))
    else $error("item count overflow");

  // the last request of a run closes the input until the run is emitted
  assert property (@(posedge clk) disable iff (rst)
      (in_valid && in_ready && last) |=> !in_ready)
    else $error("input reopened during sort");

  // taking the final sorted value reopens the input
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_ready && last_out) |=> (in_ready && !out_valid))
    else $error("input not reopened after run");

endmodule
`default_nettype wire

// ----- test/lsd_radix_sort_base10_tb.sv -----
// ----------------------------------------------------------------------------
// lsd_radix_sort_base10_tb
// Streams runs of values into the base-10 radix sorter and checks each sorted
// value and its end-of-run flag against a software sort of the same run.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [lrs_pkg::VAL_W-1:0] value;
  logic                      last;
} sorted_item_t;

class sort_scoreboard;
  logic [lrs_pkg::VAL_W-1:0] loaded_run[$];
  sorted_item_t              sorted_pending[$];
  int                        errors;

  function new();
    errors = 0;
  endfunction

  // a request past the store depth is dropped, but its last flag still sorts
  function void note_request(logic [lrs_pkg::VAL_W-1:0] v, logic l);
    logic [lrs_pkg::VAL_W-1:0] key;
    int i;
    int j;
    int n;
    sorted_item_t item;
    if (loaded_run.size() < lrs_pkg::MAX_ITEMS) loaded_run.push_back(v);
    if (l) begin
      n = loaded_run.size();
      for (i = 1; i < n; i++) begin
        key = loaded_run[i];
        j = i - 1;
        while (j >= 0 && loaded_run[j] > key) begin
          loaded_run[j + 1] = loaded_run[j];
          j--;
        end
        loaded_run[j + 1] = key;
      end
      for (i = 0; i < n; i++) begin
        item.value = loaded_run[i];
        item.last  = (i == n - 1);
        sorted_pending.push_back(item);
      end
      loaded_run.delete();
    end
  endfunction

  function void check_result(logic [lrs_pkg::VAL_W-1:0] v, logic l);
    sorted_item_t exp_item;
    if (sorted_pending.size() == 0) begin
      $error("unexpected result: sorted_value %0d last_out %0d", v, l);
      errors++;
    end else begin
      exp_item = sorted_pending.pop_front();
      if (v !== exp_item.value) begin
        $error("sorted_value mismatch: expected %0d, actual %0d", exp_item.value, v);
        errors++;
      end
      if (l !== exp_item.last) begin
        $error("last_out mismatch: expected %0d, actual %0d", exp_item.last, l);
        errors++;
      end
    end
  endfunction

  function int pending();
    return sorted_pending.size();
  endfunction
endclass

module lsd_radix_sort_base10_tb;
  import lrs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 3000;
  localparam int RANDOM_ITEMS = 170;
  localparam int N_DIRECTED   = 18;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [VAL_W-1:0] value = '0;
  logic             last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [VAL_W-1:0] sorted_value;
  logic             last_out;

  sort_scoreboard sb;
  int  cycle_count = 0;
  bit  tx_fast = 1'b0;
  bit  hold_req = 1'b0;

  lsd_radix_sort_base10 dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .last_out     (last_out)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // valid is only dropped when a gap follows, so it never toggles within a step
  task automatic send_item(input logic [VAL_W-1:0] v, input logic l);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_request(v, l);
  endtask

  task automatic wait_sorted_out();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // values spread over every decimal width, including powers of 10 and the values just below them
  function automatic logic [VAL_W-1:0] rand_value();
    logic [31:0] p;
    int k;
    p = 1;
    k = $urandom_range(1, 9);
    repeat (k) p = p * 10;
    case ($urandom_range(0, 4))
      0: return VAL_W'($urandom);
      1: return VAL_W'($urandom_range(0, 9));
      2: return VAL_W'($urandom_range(0, 1) ? p : p - 1);
      default: return VAL_W'($urandom % p);
    endcase
  endfunction

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int stall;
    bit rx_fast;
    rx_fast = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_fast = ~rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 19);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(sorted_value, last_out);
    end
  end

  initial begin
    logic [VAL_W-1:0] dir_vals [N_DIRECTED];
    bit dir_last [N_DIRECTED];
    int sent;
    int run_len;
    int i;

    dir_vals = '{
      31'd0,
      31'h7FFF_FFFF,
      31'd0, 31'd0, 31'd0,
      31'd1000000000, 31'd9, 31'd10, 31'd0, 31'h7FFF_FFFF,
      31'd5, 31'd99, 31'd5, 31'd1, 31'd100,
      31'd3, 31'd1, 31'd2
    };
    dir_last = '{
      1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1
    };

    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single zero, single max, all-zero run, mixed widths with duplicates
    for (i = 0; i < N_DIRECTED; i++) send_item(dir_vals[i], dir_last[i]);
    wait_sorted_out();

    // overflowing run: dropped requests carry larger values and the last flag;
    // the receiver holds off meanwhile so the next run stalls at the input
    hold_req = 1'b1;
    run_len = MAX_ITEMS + $urandom_range(1, 4);
    for (i = 0; i < run_len; i++) begin
      if (i < MAX_ITEMS)
        send_item(VAL_W'($urandom_range(0, 99999)), 1'b0);
      else
        send_item(VAL_W'($urandom | 32'h4000_0000), i == run_len - 1);
    end
    sent = N_DIRECTED + run_len;

    while (sent < RANDOM_ITEMS) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(1, 12);
      for (i = 0; i < run_len; i++) send_item(rand_value(), i == run_len - 1);
      sent += run_len;
    end
    wait_sorted_out();

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- lsd_radix_sort_base10.f -----
sv/lrs_pkg.sv
sv/lrs_ram.sv
sv/lrs_digit.sv
sv/lsd_radix_sort_base10.sv
test/lsd_radix_sort_base10_tb.sv
